// File: rtl/gdcs_pkg.sv
// shared types and constants for the gamepad drive command smoother
// no dependencies
package gdcs_pkg;

	localparam int AxisW    = 16;
	localparam int PosW     = 15;
	localparam int CfgW     = 15;
	localparam int CfgIdxW  = 1;
	localparam int InDataW  = 56;
	localparam int OutDataW = 56;

	localparam logic [CfgW-1:0] ParkedThresholdRst = 15'd32440;
	localparam logic [CfgW-1:0] SmoothingFactorRst = 15'd3277;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PARKED_THRESHOLD = 1'b0,
		CFG_SMOOTHING_FACTOR = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_DISABLE = 2'd1,
		EV_ENABLE  = 2'd2
	} event_t;

	typedef struct packed {
		op_t                     operation;
		logic signed [AxisW-1:0] brake_axis;
		logic signed [AxisW-1:0] throttle_axis;
		logic signed [AxisW-1:0] steering_axis;
		logic                    back_pressed;
		logic                    start_pressed;
	} item_t;

	typedef struct packed {
		event_t                  enable_event;
		logic                    command_valid;
		logic [PosW-1:0]         brake_cmd;
		logic [PosW-1:0]         throttle_cmd;
		logic signed [AxisW-1:0] steer_cmd;
	} result_t;

	// handshake between the input stage and the output register
	typedef struct packed {
		logic out_free;
		logic advance;
	} flow_t;

	// clamp the most negative code to keep the axis symmetric
	function automatic logic signed [AxisW-1:0] sat_axis(input logic signed [AxisW-1:0] a);
		logic signed [AxisW-1:0] r;
		r = a;
		if (a == {1'b1, {(AxisW-1){1'b0}}}) begin
			r = {1'b1, {(AxisW-2){1'b0}}, 1'b1};
		end
		return r;
	endfunction

	// (32768 - a) >> 1 for a in -32767..32767
	function automatic logic [PosW-1:0] trigger_map(input logic signed [AxisW-1:0] a);
		logic [AxisW:0] d;
		d = 17'd32768 - {a[AxisW-1], a};
		return d[PosW:1];
	endfunction

endpackage

// File: rtl/gamepad_drive_command_smoother.sv
// top level of the gamepad drive command smoother: ports, configuration, output register
// depends on gdcs_pkg, gdcs_in_stage, gdcs_step
//
// one result item for every input item, one item per cycle sustained while the output
// is not stalled: an item is registered in the input stage, goes through the state logic
// and the single steering multiply, and lands in the output register. the output
// register lets the next item be taken while a result waits; a stalled output holds the
// input stage and the control state together. samples (tuser = 0) stay ignored
// until both triggers read above parked_threshold; afterwards they refresh the
// held brake, throttle and steering target and report back/start rising edges as
// disable/enable events. ticks (tuser = 1) while enabled step the steering
// exponential average and emit the command. configuration writes take effect at
// once and are always ready; write them only while the block is idle.
module gamepad_drive_command_smoother import gdcs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// input items
	input  logic                s_tvalid,
	output logic                s_tready,
	// brake_axis[15:0], throttle_axis[31:16], steering_axis[47:32],
	// back_pressed[48], start_pressed[49], zero[55:50]
	input  logic [InDataW-1:0]  s_tdata,
	// operation[0]
	input  logic                s_tuser,
	// result items
	output logic                m_tvalid,
	input  logic                m_tready,
	// enable_event[1:0], command_valid[2], brake_cmd[17:3],
	// throttle_cmd[32:18], steer_cmd[48:33], zero[55:49]
	output logic [OutDataW-1:0] m_tdata,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgW-1:0]     cfg_data
);

	item_t           in_item, item_s1;
	logic            valid_s1;
	flow_t           flow;
	result_t         result, result_q;
	logic            out_free;
	logic [CfgW-1:0] parked_threshold_q, smoothing_factor_q;

	// unpack the input bus
	assign in_item.operation     = op_t'(s_tuser);
	assign in_item.brake_axis    = s_tdata[15:0];
	assign in_item.throttle_axis = s_tdata[31:16];
	assign in_item.steering_axis = s_tdata[47:32];
	assign in_item.back_pressed  = s_tdata[48];
	assign in_item.start_pressed = s_tdata[49];

	// output register frees when empty or being drained
	assign out_free = !m_tvalid || m_tready;

	gdcs_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.out_free (out_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.flow     (flow)
	);

	gdcs_step u_step (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_s1          (item_s1),
		.flow             (flow),
		.parked_threshold (parked_threshold_q),
		.smoothing_factor (smoothing_factor_q),
		.result           (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (flow.out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.advance) begin
			result_q <= result;
		end
	end

	assign m_tdata = {7'd0, result_q.steer_cmd, result_q.throttle_cmd,
		result_q.brake_cmd, result_q.command_valid, result_q.enable_event};

	// configuration registers, never back-pressured
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parked_threshold_q <= ParkedThresholdRst;
			smoothing_factor_q <= SmoothingFactorRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PARKED_THRESHOLD: parked_threshold_q <= cfg_data;
				CFG_SMOOTHING_FACTOR: smoothing_factor_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/gdcs_in_stage.sv
// input register stage of the gamepad drive command smoother
// depends on gdcs_pkg
module gdcs_in_stage import gdcs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	input  logic  out_free,
	output logic  valid_s1,
	output item_t item_s1,
	output flow_t flow
);

	assign flow.out_free = out_free;
	assign flow.advance  = valid_s1 && out_free;
	assign in_ready      = !valid_s1 || flow.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: rtl/gdcs_step.sv
// control state and per-item result logic of the gamepad drive command smoother
// depends on gdcs_pkg
module gdcs_step import gdcs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  item_t           item_s1,
	input  flow_t           flow,
	input  logic [CfgW-1:0] parked_threshold,
	input  logic [CfgW-1:0] smoothing_factor,
	output result_t         result
);

	logic                    initialized_q, enabled_q, last_back_q, last_start_q;
	logic [PosW-1:0]         brake_hold_q, throttle_hold_q;
	logic signed [AxisW-1:0] target_q, average_q;

	logic signed [AxisW-1:0] brake_a, throttle_a, steer_a;
	logic                    is_tick, parked, back_rise, start_rise;
	logic signed [AxisW:0]   diff;
	logic signed [2*AxisW:0] prod;
	logic signed [2*AxisW:0] step_amt;
	logic signed [AxisW:0]   avg_sum;
	logic signed [AxisW-1:0] avg_next;

	assign brake_a    = sat_axis(item_s1.brake_axis);
	assign throttle_a = sat_axis(item_s1.throttle_axis);
	assign steer_a    = sat_axis(item_s1.steering_axis);
	assign is_tick    = (item_s1.operation == OP_TICK);
	assign parked     = (brake_a > $signed({2'b00, parked_threshold}))
		&& (throttle_a > $signed({2'b00, parked_threshold}));
	assign back_rise  = !last_back_q && item_s1.back_pressed;
	assign start_rise = !last_start_q && item_s1.start_pressed;

	// avg + floor(((target - avg) * f + half) / 2^15)
	assign diff     = {target_q[AxisW-1], target_q} - {average_q[AxisW-1], average_q};
	assign prod     = diff * $signed({1'b0, smoothing_factor});
	assign step_amt = (prod + (2*AxisW+1)'(16384)) >>> 15;
	assign avg_sum  = {average_q[AxisW-1], average_q} + step_amt[AxisW:0];
	assign avg_next = avg_sum[AxisW-1:0];

	always_comb begin
		result = '0;
		result.enable_event = EV_NONE;
		if (!is_tick) begin
			if (initialized_q) begin
				priority if (back_rise) begin
					result.enable_event = EV_DISABLE;
				end else if (start_rise) begin
					result.enable_event = EV_ENABLE;
				end else begin
					result.enable_event = EV_NONE;
				end
			end
		end else if (enabled_q) begin
			result.command_valid = 1'b1;
			result.brake_cmd     = brake_hold_q;
			result.throttle_cmd  = throttle_hold_q;
			result.steer_cmd     = avg_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q   <= 1'b0;
			enabled_q       <= 1'b0;
			last_back_q     <= 1'b0;
			last_start_q    <= 1'b0;
			brake_hold_q    <= '0;
			throttle_hold_q <= '0;
			target_q        <= '0;
			average_q       <= '0;
		end else if (flow.advance) begin
			if (!is_tick) begin
				if (initialized_q) begin
					brake_hold_q    <= trigger_map(brake_a);
					throttle_hold_q <= trigger_map(throttle_a);
					target_q        <= -steer_a;
					if (back_rise) begin
						enabled_q <= 1'b0;
					end else if (start_rise) begin
						enabled_q <= 1'b1;
					end
					last_back_q  <= item_s1.back_pressed;
					last_start_q <= item_s1.start_pressed;
				end else if (parked) begin
					initialized_q <= 1'b1;
				end
			end else if (enabled_q) begin
				average_q <= avg_next;
			end
		end
	end

endmodule

// File: rtl/gdcs_checker.sv
// port-level checks for the gamepad drive command smoother, bound to the top level
// depends on gdcs_pkg
module gdcs_checker import gdcs_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [InDataW-1:0]  s_tdata,
	input logic                s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [CfgIdxW-1:0]  cfg_index,
	input logic [CfgW-1:0]     cfg_data
);

	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result shown during reset");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined enable event");

	a_event_not_on_command: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == EV_NONE)
		else $error("event reported with a drive command");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[OutDataW-1:3] == '0)
		else $error("command fields set without command_valid");

endmodule

bind gamepad_drive_command_smoother gdcs_checker u_gdcs_checker (.*);
